// ===== src/msd_pkg.sv =====
package msd_pkg;

    localparam int MAX_SWITCHES_DEF = 16;

    localparam int IDX_W   = 4;
    localparam int CNT_W   = 8;
    localparam int MASK_W  = 16;
    localparam int ACT_W   = 5;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    typedef enum logic [1:0] {
        PH_RELEASED    = 2'd0,
        PH_PREPRESSED  = 2'd1,
        PH_PRESSED     = 2'd2,
        PH_PRERELEASED = 2'd3
    } phase_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_PREPRESSED  = 3'd0,
        REG_PRESSED     = 3'd1,
        REG_PRERELEASED = 3'd2,
        REG_RELEASED    = 3'd3,
        REG_PULL_UP     = 3'd4,
        REG_ACTIVE      = 3'd5
    } cfg_addr_t;

    typedef struct packed {
        logic [CNT_W-1:0]  prepressed_count;
        logic [CNT_W-1:0]  pressed_count;
        logic [CNT_W-1:0]  prereleased_count;
        logic [CNT_W-1:0]  released_count;
        logic [MASK_W-1:0] pull_up_mask;
        logic [ACT_W-1:0]  active_switches;
    } cfg_t;

    localparam logic [CNT_W-1:0]  PREPRESSED_RST  = 8'd3;
    localparam logic [CNT_W-1:0]  PRESSED_RST     = 8'd25;
    localparam logic [CNT_W-1:0]  PRERELEASED_RST = 8'd20;
    localparam logic [CNT_W-1:0]  RELEASED_RST    = 8'd25;
    localparam logic [MASK_W-1:0] PULL_UP_RST     = 16'hFFFF;
    localparam logic [ACT_W-1:0]  ACTIVE_RST      = 5'd16;

endpackage

// ===== src/msd_step.sv =====
module msd_step
(
    input  msd_pkg::cfg_t                 cfg,
    input  logic                          pull_up,
    input  logic                          pin_level,
    input  msd_pkg::phase_t               phase_cur,
    input  logic [msd_pkg::CNT_W-1:0]     count_cur,
    output msd_pkg::phase_t               phase_next,
    output logic [msd_pkg::CNT_W-1:0]     count_next
);

    logic                      active;
    logic [msd_pkg::CNT_W-1:0] count_inc;

    assign active    = pull_up ? !pin_level : pin_level;
    assign count_inc = msd_pkg::CNT_W'(count_cur + 1'b1);

    always_comb
    begin
        phase_next = phase_cur;
        count_next = count_cur;
        case (phase_cur)
            msd_pkg::PH_RELEASED:
            begin
                if (active)
                begin
                    count_next = count_inc;
                    if (count_inc == cfg.prepressed_count)
                    begin
                        phase_next = msd_pkg::PH_PREPRESSED;
                    end
                end
                else
                begin
                    count_next = '0;
                end
            end
            msd_pkg::PH_PREPRESSED:
            begin
                if (active)
                begin
                    count_next = count_inc;
                    if (count_inc == cfg.pressed_count)
                    begin
                        phase_next = msd_pkg::PH_PRESSED;
                        count_next = '0;
                    end
                end
                else
                begin
                    count_next = '0;
                    phase_next = msd_pkg::PH_RELEASED;
                end
            end
            msd_pkg::PH_PRESSED:
            begin
                if (!active)
                begin
                    count_next = count_inc;
                    if (count_inc == cfg.prereleased_count)
                    begin
                        phase_next = msd_pkg::PH_PRERELEASED;
                    end
                end
                else
                begin
                    count_next = '0;
                end
            end
            default:
            begin
                if (!active)
                begin
                    count_next = count_inc;
                    if (count_inc == cfg.released_count)
                    begin
                        phase_next = msd_pkg::PH_RELEASED;
                        count_next = '0;
                    end
                end
                else
                begin
                    count_next = '0;
                    phase_next = msd_pkg::PH_PRESSED;
                end
            end
        endcase
    end

endmodule

// ===== src/multi_switch_debouncer_core.sv =====
// An accepted input beat goes to the input register, then to the result register.
// Throughput: 1 beat per cycle unless the output stalls; per-switch phase and
// counter flops are read, updated and, for a valid index, written back on advance.
// Reset: async active low; all switches released with zero counters, config
// registers at their defaults, both stages empty.
module multi_switch_debouncer_core
#(
    parameter int MAX_SWITCHES = msd_pkg::MAX_SWITCHES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] switch_index, [4] pin_level, [7:5] zero
    input  logic [7:0]                      s_axis_tdata,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] reported_index, [5:4] debounced_state, [6] index_error, [7] zero
    output logic [7:0]                      m_axis_tdata,

    input  logic                            cfg_we,
    input  logic [msd_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [msd_pkg::CFG_D_W-1:0]     cfg_wdata
);

    localparam int DEPTH = (MAX_SWITCHES < (1 << msd_pkg::IDX_W)) ?
                           MAX_SWITCHES : (1 << msd_pkg::IDX_W);
    localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [msd_pkg::IDX_W:0] DEPTH_L = (msd_pkg::IDX_W + 1)'(DEPTH);

    msd_pkg::cfg_t cfg_reg;

    msd_pkg::phase_t                 phase_reg [DEPTH];
    logic [msd_pkg::CNT_W-1:0]       count_reg [DEPTH];

    logic                            in_valid_reg;
    logic [msd_pkg::IDX_W-1:0]       in_idx_reg;
    logic                            in_level_reg;

    logic                            out_valid_reg;
    logic [msd_pkg::IDX_W-1:0]       out_idx_reg;
    msd_pkg::phase_t                 out_phase_reg;
    logic                            out_err_reg;

    logic                            advance;
    logic                            idx_err;
    logic [SEL_W-1:0]                sel;
    msd_pkg::phase_t                 phase_cur;
    logic [msd_pkg::CNT_W-1:0]       count_cur;
    msd_pkg::phase_t                 phase_next;
    logic [msd_pkg::CNT_W-1:0]       count_next;
    logic                            pull_up;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign idx_err = ({1'b0, in_idx_reg} >= cfg_reg.active_switches) ||
                     ({1'b0, in_idx_reg} >= DEPTH_L);
    assign sel       = SEL_W'(in_idx_reg);
    assign phase_cur = phase_reg[sel];
    assign count_cur = count_reg[sel];
    assign pull_up   = cfg_reg.pull_up_mask[in_idx_reg];

    msd_step u_step
    (
        .cfg        (cfg_reg),
        .pull_up    (pull_up),
        .pin_level  (in_level_reg),
        .phase_cur  (phase_cur),
        .count_cur  (count_cur),
        .phase_next (phase_next),
        .count_next (count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prepressed_count  <= msd_pkg::PREPRESSED_RST;
            cfg_reg.pressed_count     <= msd_pkg::PRESSED_RST;
            cfg_reg.prereleased_count <= msd_pkg::PRERELEASED_RST;
            cfg_reg.released_count    <= msd_pkg::RELEASED_RST;
            cfg_reg.pull_up_mask      <= msd_pkg::PULL_UP_RST;
            cfg_reg.active_switches   <= msd_pkg::ACTIVE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                msd_pkg::REG_PREPRESSED:
                    cfg_reg.prepressed_count  <= cfg_wdata[msd_pkg::CNT_W-1:0];
                msd_pkg::REG_PRESSED:
                    cfg_reg.pressed_count     <= cfg_wdata[msd_pkg::CNT_W-1:0];
                msd_pkg::REG_PRERELEASED:
                    cfg_reg.prereleased_count <= cfg_wdata[msd_pkg::CNT_W-1:0];
                msd_pkg::REG_RELEASED:
                    cfg_reg.released_count    <= cfg_wdata[msd_pkg::CNT_W-1:0];
                msd_pkg::REG_PULL_UP:
                    cfg_reg.pull_up_mask      <= cfg_wdata[msd_pkg::MASK_W-1:0];
                msd_pkg::REG_ACTIVE:
                    cfg_reg.active_switches   <= cfg_wdata[msd_pkg::ACT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // per-switch state: update on a valid-index beat moving to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                phase_reg[i] <= msd_pkg::PH_RELEASED;
                count_reg[i] <= '0;
            end
        end
        else if (advance && !idx_err)
        begin
            phase_reg[sel] <= phase_next;
            count_reg[sel] <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_idx_reg   <= s_axis_tdata[msd_pkg::IDX_W-1:0];
            in_level_reg <= s_axis_tdata[msd_pkg::IDX_W];
        end
        if (advance)
        begin
            out_idx_reg   <= in_idx_reg;
            out_err_reg   <= idx_err;
            out_phase_reg <= idx_err ? msd_pkg::PH_RELEASED : phase_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_err_reg, out_phase_reg, out_idx_reg};

    a_err_state_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |-> (m_axis_tdata[5:4] == msd_pkg::PH_RELEASED))
        else $error("rejected index reports nonzero state");

    a_no_skip_press : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !idx_err && phase_cur == msd_pkg::PH_RELEASED)
            |-> (phase_next != msd_pkg::PH_PRESSED))
        else $error("switch jumped from released to pressed");

    a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while pipeline can advance");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced beat missing at output");

endmodule
